[rtl/ptsm_pkg.sv]
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared types and constants of the modular Taylor shift block: the word
// width, sequencer states and the request/response bundles of the
// modular multiplier.
// ----------------------------------------------------------------------------
package ptsm_pkg;

	localparam int W      = 64;
	localparam int STEPS  = 64;
	localparam int STEP_W = 7;

	// configuration register indexes
	localparam logic [1:0] CFG_MODULUS = 2'd0;
	localparam logic [1:0] CFG_SHIFT   = 2'd1;

	typedef enum logic [5:0] {
		S_IDLE,
		S_RC_GO, S_RC_WT,
		S_RD_RD, S_RD_GO, S_RD_WT,
		S_FC_RD, S_FC_WT1, S_FC_GO2, S_FC_WT2,
		S_KN_WR, S_KN_WT,
		S_KC_RD, S_KC_GO, S_KC_WT, S_KC_GO2, S_KC_WT2,
		S_CV_RD, S_CV_GO, S_CV_WT,
		S_FS_GO, S_FS_WT,
		S_EU_CHK, S_EU_DIV, S_EU_MUL, S_EU_WT,
		S_SC_RD, S_SC_GO, S_SC_WT, S_SC_GO2, S_SC_WT2,
		S_EM_RD, S_EM_LD, S_EM_WT
	} state_t;

	typedef struct packed {
		logic         start;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [W-1:0] res;
	} mul_rsp_t;

endpackage

[rtl/poly_taylor_shift_mod_n_top.sv]
// ----------------------------------------------------------------------------
// poly_taylor_shift_mod_n_top
// Taylor shift p(x) -> p(x+c) modulo n by factorial scaling and convolution.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry coeff_in and last_in, lowest degree first; up to
//   MAX_LEN coefficients are kept, later ones are dropped. The beat with
//   last_in set starts the computation; in_stall stays high from then on
//   until the last result beat has been taken.
//   Results leave as one beat per coefficient, lowest degree first, with
//   last_out on the highest degree and no_inverse set on every beat when,
//   outside pass-through, (m!)^2 has no inverse modulo n (coeff_out is then 0).
//   Throughput: one input beat per cycle while loading. All products run
//   on one shared bit-serial modular multiplier, one at a time; each
//   extended-Euclid step first divides with a separate bit-serial
//   restoring divider and then multiplies. Pass-through (c mod n = 0 or
//   a single coefficient) only reduces each coefficient modulo n.
//   Each result beat is read from the coefficient ram and loaded into the
//   output register; a stall holds the beat there and the sequencer waits.
//   Reset empties the load count; the coefficient, kernel and product RAMs
//   need no clearing. Registers modulus and shift reset to 2 and 0 and are
//   written through cfg_we/cfg_index/cfg_data; the user must write them
//   only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module poly_taylor_shift_mod_n_top #(
	parameter int MAX_LEN = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [ptsm_pkg::W-1:0] coeff_in,
	input  logic                   last_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ptsm_pkg::W-1:0] coeff_out,
	output logic                   last_out,
	output logic                   no_inverse,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [ptsm_pkg::W-1:0] cfg_data
);
	import ptsm_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	state_t state_q, state_d;

	logic [W-1:0]  modulus_q, shift_q, n_eff;
	logic [CW-1:0] cnt_q, len_q, idx_q, j_q, m_w;
	logic [W-1:0]  c_q, fac_q, kv_q, d_q, acc_q, f_q;
	logic [W-1:0]  r0_q, r1_q, s0_q, s1_q;
	logic [W-1:0]  dq_q, drem_q;
	logic [STEP_W-1:0] dcnt_q;
	logic          err_q;
	logic          out_valid_q, last_out_q, no_inv_q;
	logic [W-1:0]  coeff_out_q;

	logic          in_acc, out_acc, room;
	logic [W-1:0]  idx_ext;
	logic [W:0]    sum_w, sub_w;
	logic [W-1:0]  accn, subn;
	logic [W:0]    rem_sh;
	logic          rem_ge;

	mul_req_t      mreq;
	mul_rsp_t      mrsp;

	logic          c_we, k_we, p_we;
	logic [AW-1:0] c_waddr, c_raddr, k_waddr, k_raddr, p_waddr, p_raddr;
	logic [W-1:0]  c_wdata, k_wdata, p_wdata;
	logic [W-1:0]  c_rdata, k_rdata, p_rdata;

	// handshakes and small helpers
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign room    = cnt_q < CW'(MAX_LEN);
	assign n_eff   = (modulus_q < W'(2)) ? W'(2) : modulus_q;
	assign m_w     = len_q - 1'b1;
	assign idx_ext = {{(W-CW){1'b0}}, idx_q};

	// modular add for the convolution sum, modular subtract for euclid
	always_comb begin
		sum_w = {1'b0, acc_q} + {1'b0, mrsp.res};
		accn  = (sum_w >= {1'b0, n_eff}) ? W'(sum_w - {1'b0, n_eff}) : sum_w[W-1:0];
		sub_w = {1'b0, s0_q} - {1'b0, mrsp.res};
		subn  = sub_w[W] ? W'(sub_w[W-1:0] + n_eff) : sub_w[W-1:0];
	end

	// one restoring divider step
	always_comb begin
		rem_sh = {drem_q, dq_q[W-1]};
		rem_ge = rem_sh >= {1'b0, r1_q};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(2);
			shift_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_SHIFT:   shift_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_acc && last_in) state_d = S_RC_GO;
			S_RC_GO:  state_d = S_RC_WT;
			S_RC_WT:  if (mrsp.done) state_d = S_RD_RD;
			S_RD_RD:  state_d = S_RD_GO;
			S_RD_GO:  state_d = S_RD_WT;
			S_RD_WT: begin
				if (mrsp.done) begin
					if (idx_q != m_w) begin
						state_d = S_RD_RD;
					end else if (c_q == '0 || len_q <= CW'(1)) begin
						state_d = S_EM_RD;
					end else if (len_q == CW'(2)) begin
						state_d = S_KN_WR;
					end else begin
						state_d = S_FC_RD;
					end
				end
			end
			S_FC_RD:  state_d = S_FC_WT1;
			S_FC_WT1: if (mrsp.done) state_d = S_FC_GO2;
			S_FC_GO2: state_d = S_FC_WT2;
			S_FC_WT2: if (mrsp.done) state_d = (idx_q == m_w) ? S_KN_WR : S_FC_RD;
			S_KN_WR:  state_d = (idx_q == '0) ? S_KC_RD : S_KN_WT;
			S_KN_WT:  if (mrsp.done) state_d = S_KN_WR;
			S_KC_RD:  state_d = S_KC_GO;
			S_KC_GO:  state_d = S_KC_WT;
			S_KC_WT:  if (mrsp.done) state_d = S_KC_GO2;
			S_KC_GO2: state_d = S_KC_WT2;
			S_KC_WT2: if (mrsp.done) state_d = (idx_q == m_w) ? S_CV_RD : S_KC_RD;
			S_CV_RD:  state_d = S_CV_GO;
			S_CV_GO:  state_d = S_CV_WT;
			S_CV_WT: begin
				if (mrsp.done) begin
					state_d = (j_q == idx_q && idx_q == m_w) ? S_FS_GO : S_CV_RD;
				end
			end
			S_FS_GO:  state_d = S_FS_WT;
			S_FS_WT:  if (mrsp.done) state_d = S_EU_CHK;
			S_EU_CHK: begin
				if (r1_q != '0) begin
					state_d = S_EU_DIV;
				end else begin
					state_d = (r0_q == W'(1)) ? S_SC_RD : S_EM_RD;
				end
			end
			S_EU_DIV: if (dcnt_q == STEP_W'(1)) state_d = S_EU_MUL;
			S_EU_MUL: state_d = S_EU_WT;
			S_EU_WT:  if (mrsp.done) state_d = S_EU_CHK;
			S_SC_RD:  state_d = S_SC_GO;
			S_SC_GO:  state_d = S_SC_WT;
			S_SC_WT:  if (mrsp.done) state_d = (idx_q == '0) ? S_EM_RD : S_SC_GO2;
			S_SC_GO2: state_d = S_SC_WT2;
			S_SC_WT2: if (mrsp.done) state_d = S_SC_RD;
			S_EM_RD:  state_d = S_EM_LD;
			S_EM_LD:  state_d = S_EM_WT;
			S_EM_WT:  if (out_acc) state_d = (idx_q == m_w) ? S_IDLE : S_EM_RD;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs: multiplier requests, ram ports, input stall
	always_comb begin
		mreq     = '0;
		in_stall = (state_q != S_IDLE);
		c_we     = 1'b0;
		c_waddr  = idx_q[AW-1:0];
		c_wdata  = mrsp.res;
		c_raddr  = idx_q[AW-1:0];
		k_we     = 1'b0;
		k_waddr  = idx_q[AW-1:0];
		k_wdata  = mrsp.res;
		k_raddr  = idx_q[AW-1:0];
		p_we     = 1'b0;
		p_waddr  = idx_q[AW-1:0];
		p_wdata  = accn;
		p_raddr  = AW'(m_w - idx_q);
		case (state_q)
			S_IDLE: begin
				c_we    = in_acc && room;
				c_waddr = cnt_q[AW-1:0];
				c_wdata = coeff_in;
			end
			S_RC_GO: begin
				mreq = '{start: 1'b1, a: W'(1), b: shift_q};
			end
			S_RD_GO: begin
				mreq = '{start: 1'b1, a: W'(1), b: c_rdata};
			end
			S_RD_WT, S_FC_WT2, S_SC_WT: begin
				c_we = mrsp.done;
			end
			S_FC_RD: begin
				mreq = '{start: 1'b1, a: fac_q, b: idx_ext};
			end
			S_FC_GO2: begin
				mreq = '{start: 1'b1, a: c_rdata, b: fac_q};
			end
			S_KN_WR: begin
				k_we    = 1'b1;
				k_wdata = kv_q;
				mreq    = '{start: (idx_q != '0), a: kv_q, b: idx_ext};
			end
			S_KC_GO: begin
				mreq = '{start: 1'b1, a: k_rdata, b: d_q};
			end
			S_KC_WT: begin
				k_we = mrsp.done;
			end
			S_KC_GO2: begin
				mreq = '{start: 1'b1, a: d_q, b: c_q};
			end
			S_CV_RD, S_CV_GO: begin
				c_raddr = AW'(m_w - j_q);
				k_raddr = AW'(idx_q - j_q);
				if (state_q == S_CV_GO) begin
					mreq = '{start: 1'b1, a: c_rdata, b: k_rdata};
				end
			end
			S_CV_WT: begin
				p_we = mrsp.done && (j_q == idx_q);
			end
			S_FS_GO: begin
				mreq = '{start: 1'b1, a: fac_q, b: fac_q};
			end
			S_EU_MUL: begin
				mreq = '{start: 1'b1, a: s1_q, b: dq_q};
			end
			S_SC_GO: begin
				mreq = '{start: 1'b1, a: p_rdata, b: f_q};
			end
			S_SC_GO2: begin
				mreq = '{start: 1'b1, a: f_q, b: idx_ext};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_acc) begin
				if (last_in) begin
					cnt_q <= '0;
				end else if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == S_EM_LD) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && last_in) begin
					len_q <= room ? cnt_q + 1'b1 : cnt_q;
				end
				err_q <= 1'b0;
				idx_q <= '0;
			end
			S_RC_WT: if (mrsp.done) c_q <= mrsp.res;
			S_RD_WT: begin
				if (mrsp.done) begin
					fac_q <= W'(1);
					kv_q  <= W'(1);
					if (idx_q != m_w) begin
						idx_q <= idx_q + 1'b1;
					end else if (c_q == '0 || len_q <= CW'(1)) begin
						idx_q <= '0;
					end else if (len_q == CW'(2)) begin
						idx_q <= m_w;
					end else begin
						idx_q <= CW'(2);
					end
				end
			end
			S_FC_WT1: if (mrsp.done) fac_q <= mrsp.res;
			S_FC_WT2: begin
				if (mrsp.done) begin
					idx_q <= (idx_q == m_w) ? m_w : idx_q + 1'b1;
				end
			end
			S_KN_WR: begin
				if (idx_q == '0) begin
					d_q   <= c_q;
					idx_q <= CW'(1);
				end
			end
			S_KN_WT: begin
				if (mrsp.done) begin
					kv_q  <= mrsp.res;
					idx_q <= idx_q - 1'b1;
				end
			end
			S_KC_WT2: begin
				if (mrsp.done) begin
					d_q   <= mrsp.res;
					idx_q <= (idx_q == m_w) ? '0 : idx_q + 1'b1;
					j_q   <= '0;
					acc_q <= '0;
				end
			end
			S_CV_WT: begin
				if (mrsp.done) begin
					if (j_q == idx_q) begin
						j_q   <= '0;
						acc_q <= '0;
						idx_q <= idx_q + 1'b1;
					end else begin
						j_q   <= j_q + 1'b1;
						acc_q <= accn;
					end
				end
			end
			S_FS_WT: begin
				if (mrsp.done) begin
					r0_q <= n_eff;
					r1_q <= mrsp.res;
					s0_q <= '0;
					s1_q <= W'(1);
				end
			end
			S_EU_CHK: begin
				if (r1_q != '0) begin
					dq_q   <= r0_q;
					drem_q <= '0;
					dcnt_q <= STEP_W'(STEPS);
				end else if (r0_q == W'(1)) begin
					f_q   <= s0_q;
					idx_q <= m_w;
				end else begin
					err_q <= 1'b1;
					idx_q <= '0;
				end
			end
			S_EU_DIV: begin
				dq_q   <= {dq_q[W-2:0], rem_ge};
				drem_q <= rem_ge ? W'(rem_sh - {1'b0, r1_q}) : rem_sh[W-1:0];
				dcnt_q <= dcnt_q - 1'b1;
			end
			S_EU_WT: begin
				if (mrsp.done) begin
					s0_q <= s1_q;
					s1_q <= subn;
					r0_q <= r1_q;
					r1_q <= drem_q;
				end
			end
			S_SC_WT2: begin
				if (mrsp.done) begin
					f_q   <= mrsp.res;
					idx_q <= idx_q - 1'b1;
				end
			end
			S_EM_LD: begin
				coeff_out_q <= err_q ? '0 : c_rdata;
				last_out_q  <= (idx_q == m_w);
				no_inv_q    <= err_q;
			end
			S_EM_WT: begin
				if (out_acc) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	ptsm_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.n      (n_eff),
		.rsp    (mrsp)
	);

	ptsm_ram #(.WIDTH(W), .DEPTH(MAX_LEN)) u_coeff_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	ptsm_ram #(.WIDTH(W), .DEPTH(MAX_LEN)) u_kernel_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	ptsm_ram #(.WIDTH(W), .DEPTH(MAX_LEN)) u_product_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign out_valid  = out_valid_q;
	assign coeff_out  = coeff_out_q;
	assign last_out   = last_out_q;
	assign no_inverse = no_inv_q;

`ifndef SYNTHESIS
	// a result beat is only held while the sequencer waits for it
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_EM_WT)
		else $error("result beat outside emit wait");

	// the shared multiplier is never restarted while running
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mrsp.busy)
		else $error("multiplier started while busy");

	// the last result beat returns the block to loading
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_out_q |=> state_q == S_IDLE && cnt_q == '0)
		else $error("block not idle after last result");
`endif

endmodule

[rtl/ptsm_ram.sv]
// ----------------------------------------------------------------------------
// ptsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ptsm_mulmod.sv]
// ----------------------------------------------------------------------------
// ptsm_mulmod
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle,
// msb first. a must be below n; b may be any 64-bit value.
// ----------------------------------------------------------------------------
module ptsm_mulmod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptsm_pkg::mul_req_t       req,
	input  logic [ptsm_pkg::W-1:0]   n,
	output ptsm_pkg::mul_rsp_t       rsp
);
	import ptsm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [W-1:0]      a_q;
	logic [W-1:0]      b_q;
	logic [W-1:0]      r_q;
	logic [W-1:0]      addend;
	logic [W+1:0]      t0;
	logic [W+2:0]      t1;
	logic [W+2:0]      t2;
	logic [W-1:0]      r_next;

	// 2r + a*bit lies below 3n: pick among t0, t0-n, t0-2n
	always_comb begin
		addend = b_q[W-1] ? a_q : '0;
		t0     = {1'b0, r_q, 1'b0} + {2'b00, addend};
		t1     = {1'b0, t0} - {3'b000, n};
		t2     = {1'b0, t0} - {2'b00, n, 1'b0};
		if (!t2[W+2]) begin
			r_next = t2[W-1:0];
		end else if (!t1[W+2]) begin
			r_next = t1[W-1:0];
		end else begin
			r_next = t0[W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule
